@@ hw/rtl/mtts_pkg.sv @@
// ----------------------------------------------------------------------------
// mtts_pkg
// Shared constants and codes for the multi-agent toroidal turmite stepper.
// ----------------------------------------------------------------------------
package mtts_pkg;

  localparam int DEF_GRID_ROWS = 64;
  localparam int DEF_GRID_COLS = 64;
  localparam int DEF_AGENTS    = 8;

  // Neighbourhood codes per agent table
  localparam int PATTERNS  = 32;
  localparam int PATTERN_W = 5;

  // Host command codes
  typedef enum logic [1:0] {
    CMD_WR_CELL = 2'd0,
    CMD_WR_MOVE = 2'd1,
    CMD_PLACE   = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_t;

  // Move codes; anything above MV_NW means stay
  localparam logic [3:0] MV_N  = 4'd0;
  localparam logic [3:0] MV_NE = 4'd1;
  localparam logic [3:0] MV_E  = 4'd2;
  localparam logic [3:0] MV_SE = 4'd3;
  localparam logic [3:0] MV_S  = 4'd4;
  localparam logic [3:0] MV_SW = 4'd5;
  localparam logic [3:0] MV_W  = 4'd6;
  localparam logic [3:0] MV_NW = 4'd7;

endpackage

@@ hw/rtl/mtts_ram.sv @@
// ----------------------------------------------------------------------------
// mtts_ram
// Generic single-port RAM, one access per cycle (a write also reads the old word), registered read.
// ----------------------------------------------------------------------------
module mtts_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/multi_turmite_torus_step.sv @@
// ----------------------------------------------------------------------------
// multi_turmite_torus_step
// Several turmites stepping over a toroidal one-bit grid, one agent at a time.
// ----------------------------------------------------------------------------
// Usage:
//   The host drives transactions on the input channel (in_valid/in_ready).
//   cmd selects: write a grid cell, write one move table entry of an agent,
//   place an agent, or tick. Cell writes, table writes and placements
//   produce no result; out-of-range rows, columns or agents are dropped.
//   A tick steps agents 0..AGENTS-1 in order and emits one result
//   transaction per agent on the output channel (out_valid/out_ready), with
//   last set on the final agent.
//   Each agent goes through position load, five reads of the single grid
//   RAM port plus one pipeline step, table read with the flip write, and
//   result push; any output stall lengthens a tick. The grid RAM port is
//   the shared unit that sets this pace.
//   in_ready is low while a tick is in progress.
//   When the receiver stalls, the result holds in the output register and
//   the sequencer waits at the push step; the last result of a tick may
//   still wait while the next input transaction is accepted.
//   Reset clears the sequencer and out_valid only; grid, positions and move
//   tables are undefined until the host writes them.
// ----------------------------------------------------------------------------
module multi_turmite_torus_step
  import mtts_pkg::*;
#(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS,
  parameter int AGENTS    = DEF_AGENTS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [5:0] row,
  input  logic [5:0] col,
  input  logic [2:0] agent_index,
  input  logic [4:0] pattern_index,
  input  logic       cell_value,
  input  logic [3:0] move_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] agent_id,
  output logic [5:0] new_row,
  output logic [5:0] new_col,
  output logic [4:0] neighbourhood,
  output logic       cell_after,
  output logic       last
);

  localparam int ROW_W  = $clog2(GRID_ROWS);
  localparam int COL_W  = $clog2(GRID_COLS);
  localparam int PROD_W = ROW_W + COL_W;
  localparam int GRID_DEPTH = GRID_ROWS * GRID_COLS;
  localparam int ADDR_W = $clog2(GRID_DEPTH);
  localparam int AG_W   = (AGENTS > 1) ? $clog2(AGENTS) : 1;
  localparam int TBL_DEPTH = AGENTS * PATTERNS;
  localparam int TBL_AW = $clog2(TBL_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_READ = 5'b00100,
    S_TBL  = 5'b01000,
    S_PUSH = 5'b10000
  } state_t;

  state_t state;

  // Agent positions, written by placement or by a step, read at the current agent
  logic [ROW_W-1:0] agent_row [AGENTS];
  logic [COL_W-1:0] agent_col [AGENTS];

  logic [AG_W-1:0]  agent;      // agent being stepped
  logic [ROW_W-1:0] cur_r;
  logic [COL_W-1:0] cur_c;
  logic [2:0]       phase;      // grid read step within S_READ
  logic [4:0]       code;       // neighbourhood, shifted in N first

  // Input field views at internal widths
  logic [ROW_W+5:0] row_ext;
  logic [COL_W+5:0] col_ext;
  logic [AG_W+2:0]  agent_ext;
  logic [ROW_W-1:0] in_r;
  logic [COL_W-1:0] in_c;
  logic [AG_W-1:0]  in_agent;
  logic             row_ok, col_ok, agent_ok;
  logic             accept;

  assign row_ext   = {{ROW_W{1'b0}}, row};
  assign col_ext   = {{COL_W{1'b0}}, col};
  assign agent_ext = {{AG_W{1'b0}}, agent_index};
  assign in_r      = row_ext[ROW_W-1:0];
  assign in_c      = col_ext[COL_W-1:0];
  assign in_agent  = agent_ext[AG_W-1:0];
  assign row_ok    = {3'b000, row} < 9'(GRID_ROWS);
  assign col_ok    = {3'b000, col} < 9'(GRID_COLS);
  assign agent_ok  = {2'b00, agent_index} < 5'(AGENTS);

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Wrapped neighbours of the current position
  logic [ROW_W-1:0] r_up, r_dn;
  logic [COL_W-1:0] c_lf, c_rt;

  assign r_up = (cur_r == '0) ? ROW_W'(GRID_ROWS - 1) : cur_r - ROW_W'(1);
  assign r_dn = (cur_r == ROW_W'(GRID_ROWS - 1)) ? '0 : cur_r + ROW_W'(1);
  assign c_lf = (cur_c == '0) ? COL_W'(GRID_COLS - 1) : cur_c - COL_W'(1);
  assign c_rt = (cur_c == COL_W'(GRID_COLS - 1)) ? '0 : cur_c + COL_W'(1);

  // Grid RAM port: host write when idle, else neighbour reads and the flip
  logic [ROW_W-1:0]  sel_r;
  logic [COL_W-1:0]  sel_c;
  logic [PROD_W-1:0] lin_addr;
  logic [ADDR_W-1:0] grid_addr;
  logic              grid_we;
  logic              grid_wdata;
  logic              grid_rdata;

  always_comb begin
    sel_r = cur_r;
    sel_c = cur_c;
    if (state == S_IDLE) begin
      sel_r = in_r;
      sel_c = in_c;
    end else begin
      case (phase)
        3'd0: sel_r = r_up;
        3'd1: sel_c = c_rt;
        3'd2: sel_r = r_dn;
        3'd3: sel_c = c_lf;
        default: ;  // centre
      endcase
    end
  end

  assign lin_addr  = PROD_W'(sel_r) * PROD_W'(GRID_COLS) + PROD_W'(sel_c);
  assign grid_addr = lin_addr[ADDR_W-1:0];

  always_comb begin
    grid_we    = 1'b0;
    grid_wdata = ~code[4];
    if (state == S_IDLE) begin
      grid_we    = accept && (cmd == CMD_WR_CELL) && row_ok && col_ok;
      grid_wdata = cell_value;
    end else if (state == S_TBL) begin
      grid_we = 1'b1;  // flip the cell underfoot
    end
  end

  mtts_ram #(
    .WIDTH (1),
    .DEPTH (GRID_DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (grid_we),
    .addr  (grid_addr),
    .wdata (grid_wdata),
    .rdata (grid_rdata)
  );

  // Move table RAM: agent-major, one entry per neighbourhood code
  logic [AG_W+4:0]   tbl_lin;
  logic [TBL_AW-1:0] tbl_addr;
  logic              tbl_we;
  logic [3:0]        tbl_rdata;

  assign tbl_lin  = (state == S_IDLE) ? {in_agent, pattern_index} : {agent, code};
  assign tbl_addr = tbl_lin[TBL_AW-1:0];
  assign tbl_we   = accept && (cmd == CMD_WR_MOVE) && agent_ok;

  mtts_ram #(
    .WIDTH (4),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .addr  (tbl_addr),
    .wdata (move_code),
    .rdata (tbl_rdata)
  );

  // Destination from the looked-up move code
  logic [ROW_W-1:0] nxt_r;
  logic [COL_W-1:0] nxt_c;

  always_comb begin
    nxt_r = cur_r;
    nxt_c = cur_c;
    case (tbl_rdata)
      MV_N:  nxt_r = r_up;
      MV_NE: begin nxt_r = r_up; nxt_c = c_rt; end
      MV_E:  nxt_c = c_rt;
      MV_SE: begin nxt_r = r_dn; nxt_c = c_rt; end
      MV_S:  nxt_r = r_dn;
      MV_SW: begin nxt_r = r_dn; nxt_c = c_lf; end
      MV_W:  nxt_c = c_lf;
      MV_NW: begin nxt_r = r_up; nxt_c = c_lf; end
      default: ;  // stay
    endcase
  end

  logic             push;
  logic             last_agent;
  logic [ROW_W+5:0] nr_ext;
  logic [COL_W+5:0] nc_ext;
  logic [AG_W+2:0]  id_ext;

  assign push       = (state == S_PUSH) && (!out_valid || out_ready);
  assign last_agent = (agent == AG_W'(AGENTS - 1));
  assign nr_ext     = {6'b000000, nxt_r};
  assign nc_ext     = {6'b000000, nxt_c};
  assign id_ext     = {3'b000, agent};

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      agent <= '0;
      phase <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (cmd == CMD_TICK)) begin
            agent <= '0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          phase <= '0;
          state <= S_READ;
        end
        S_READ: begin
          // issue reads at phases 0..4, collect each at the next phase
          phase <= phase + 3'd1;
          if (phase == 3'd5) begin
            state <= S_TBL;
          end
        end
        S_TBL: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push) begin
            if (last_agent) begin
              state <= S_IDLE;
            end else begin
              agent <= agent + AG_W'(1);
              state <= S_LOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      cur_r <= agent_row[agent];
      cur_c <= agent_col[agent];
    end
    if ((state == S_READ) && (phase != 3'd0)) begin
      code <= {grid_rdata, code[4:1]};
    end
    if (accept && (cmd == CMD_PLACE) && agent_ok && row_ok && col_ok) begin
      agent_row[in_agent] <= in_r;
      agent_col[in_agent] <= in_c;
    end else if (push) begin
      agent_row[agent] <= nxt_r;
      agent_col[agent] <= nxt_c;
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      agent_id      <= id_ext[2:0];
      new_row       <= nr_ext[5:0];
      new_col       <= nc_ext[5:0];
      neighbourhood <= code;
      cell_after    <= ~code[4];
      last          <= last_agent;
    end
  end

endmodule

@@ tb/mtts_step_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtts_step_checker
// Watches both channels of the turmite stepper, keeps its own copy of the
// grid, agent positions and move tables, and checks every agent step result.
// ----------------------------------------------------------------------------
module mtts_step_checker
  import mtts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] cmd,
  input  logic [5:0] row,
  input  logic [5:0] col,
  input  logic [2:0] agent_index,
  input  logic [4:0] pattern_index,
  input  logic       cell_value,
  input  logic [3:0] move_code,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] agent_id,
  input  logic [5:0] new_row,
  input  logic [5:0] new_col,
  input  logic [4:0] neighbourhood,
  input  logic       cell_after,
  input  logic       last,
  output int         errors,
  output int         pending,
  output int         checked
);

  localparam int ROWS   = DEF_GRID_ROWS;
  localparam int COLS   = DEF_GRID_COLS;
  localparam int NAGENT = DEF_AGENTS;

  typedef struct packed {
    logic [2:0] id;
    logic [5:0] r;
    logic [5:0] c;
    logic [4:0] nbr;
    logic       flipped;
    logic       fin;
  } agent_step_t;

  bit         grid_bit [0:ROWS*COLS-1];
  int         pos_row  [0:NAGENT-1];
  int         pos_col  [0:NAGENT-1];
  logic [3:0] moves    [0:NAGENT*PATTERNS-1];

  agent_step_t expected_steps[$];
  int          err_count = 0;
  int          step_count = 0;

  // Step every agent in index order against the grid left by the ones before.
  task automatic advance_turmites();
    int          a, r, c, up, dn, lf, rt;
    logic [4:0]  nbr;
    logic [3:0]  mv;
    agent_step_t s;
    for (a = 0; a < NAGENT; a++) begin
      r   = pos_row[a];
      c   = pos_col[a];
      up  = (r == 0) ? ROWS - 1 : r - 1;
      dn  = (r == ROWS - 1) ? 0 : r + 1;
      lf  = (c == 0) ? COLS - 1 : c - 1;
      rt  = (c == COLS - 1) ? 0 : c + 1;
      nbr = {grid_bit[r*COLS+c], grid_bit[r*COLS+lf], grid_bit[dn*COLS+c],
             grid_bit[r*COLS+rt], grid_bit[up*COLS+c]};
      mv  = moves[a*PATTERNS + nbr];
      grid_bit[r*COLS+c] = ~nbr[4];
      case (mv)
        MV_N:  r = up;
        MV_NE: begin r = up; c = rt; end
        MV_E:  c = rt;
        MV_SE: begin r = dn; c = rt; end
        MV_S:  r = dn;
        MV_SW: begin r = dn; c = lf; end
        MV_W:  c = lf;
        MV_NW: begin r = up; c = lf; end
        default: ;
      endcase
      pos_row[a] = r;
      pos_col[a] = c;
      s.id      = a[2:0];
      s.r       = r[5:0];
      s.c       = c[5:0];
      s.nbr     = nbr;
      s.flipped = ~nbr[4];
      s.fin     = (a == NAGENT - 1);
      expected_steps.push_back(s);
    end
  endtask

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      err_count++;
      if (err_count <= 40)
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    agent_step_t s;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_steps.size() == 0) begin
          err_count++;
          if (err_count <= 40)
            $display("%0t: result with nothing expected: expected none, actual agent %0d",
                     $time, agent_id);
        end else begin
          s = expected_steps.pop_front();
          check_field("agent_id", s.id, agent_id);
          check_field("new_row", s.r, new_row);
          check_field("new_col", s.c, new_col);
          check_field("neighbourhood", s.nbr, neighbourhood);
          check_field("cell_after", s.flipped, cell_after);
          check_field("last", s.fin, last);
          step_count++;
        end
      end
      if (in_valid && in_ready) begin
        case (cmd)
          CMD_WR_CELL:
            if (row < ROWS && col < COLS) grid_bit[row*COLS+col] = cell_value;
          CMD_WR_MOVE:
            if (agent_index < NAGENT) moves[agent_index*PATTERNS+pattern_index] = move_code;
          CMD_PLACE:
            if (agent_index < NAGENT && row < ROWS && col < COLS) begin
              pos_row[agent_index] = row;
              pos_col[agent_index] = col;
            end
          CMD_TICK:
            advance_turmites();
          default: ;
        endcase
      end
    end
    errors  <= err_count;
    pending <= expected_steps.size();
    checked <= step_count;
  end

endmodule

@@ tb/tb_multi_turmite_torus_step.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_turmite_torus_step
// Drives grid, table and placement writes plus ticks into the turmite
// stepper with random idling and one long output stall; the checker beside
// the block predicts every agent step and counts mismatches.
// ----------------------------------------------------------------------------
module tb_multi_turmite_torus_step;
  import mtts_pkg::*;

  localparam int ROWS        = DEF_GRID_ROWS;
  localparam int COLS        = DEF_GRID_COLS;
  localparam int NAGENT      = DEF_AGENTS;
  localparam int TOTAL_ITEMS = 330;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN       = 120;
  localparam int CYCLE_LIMIT = 300000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] cmd = CMD_WR_CELL;
  logic [5:0] row = '0;
  logic [5:0] col = '0;
  logic [2:0] agent_index = '0;
  logic [4:0] pattern_index = '0;
  logic       cell_value = 1'b0;
  logic [3:0] move_code = '0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [2:0] agent_id;
  logic [5:0] new_row;
  logic [5:0] new_col;
  logic [4:0] neighbourhood;
  logic       cell_after;
  logic       last;

  int errors, pending, checked;

  // Shared knobs between the sender and the receiver.
  bit idle_on = 1'b1;
  bit long_hold_req = 1'b0;
  bit long_hold_taken = 1'b0;
  int hold_left = 0;

  int cycle_count = 0;
  int txn_count = 0;
  int tick_count = 0;

  // Sender's view of what the host has written, so a tick never reads an
  // entry that was never written.
  bit         sh_grid [ROWS*COLS];
  bit         sh_gset [ROWS*COLS];
  logic [3:0] sh_move [NAGENT*PATTERNS];
  bit         sh_mset [NAGENT*PATTERNS];
  int         sh_row  [NAGENT];
  int         sh_col  [NAGENT];

  multi_turmite_torus_step u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .row           (row),
    .col           (col),
    .agent_index   (agent_index),
    .pattern_index (pattern_index),
    .cell_value    (cell_value),
    .move_code     (move_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .agent_id      (agent_id),
    .new_row       (new_row),
    .new_col       (new_col),
    .neighbourhood (neighbourhood),
    .cell_after    (cell_after),
    .last          (last)
  );

  mtts_step_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .row           (row),
    .col           (col),
    .agent_index   (agent_index),
    .pattern_index (pattern_index),
    .cell_value    (cell_value),
    .move_code     (move_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .agent_id      (agent_id),
    .new_row       (new_row),
    .new_col       (new_col),
    .neighbourhood (neighbourhood),
    .cell_after    (cell_after),
    .last          (last),
    .errors        (errors),
    .pending       (pending),
    .checked       (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Abort a hung run; the bound is several times the slowest legal run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random short stalls, plus one long hold-off on request so the
  // result register fills and the block stops taking input.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (long_hold_req && !long_hold_taken) begin
      long_hold_taken = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Advance the sender's view by one tick: flip and move every agent.
  task automatic shadow_tick();
    int         a, r, c, up, dn, lf, rt;
    logic [4:0] code;
    for (a = 0; a < NAGENT; a++) begin
      r    = sh_row[a];
      c    = sh_col[a];
      up   = (r == 0) ? ROWS - 1 : r - 1;
      dn   = (r == ROWS - 1) ? 0 : r + 1;
      lf   = (c == 0) ? COLS - 1 : c - 1;
      rt   = (c == COLS - 1) ? 0 : c + 1;
      code = {sh_grid[r*COLS+c], sh_grid[r*COLS+lf], sh_grid[dn*COLS+c],
              sh_grid[r*COLS+rt], sh_grid[up*COLS+c]};
      sh_grid[r*COLS+c] = ~code[4];
      case (sh_move[a*PATTERNS+code])
        MV_N:  r = up;
        MV_NE: begin r = up; c = rt; end
        MV_E:  c = rt;
        MV_SE: begin r = dn; c = rt; end
        MV_S:  r = dn;
        MV_SW: begin r = dn; c = lf; end
        MV_W:  c = lf;
        MV_NW: begin r = up; c = lf; end
        default: ;
      endcase
      sh_row[a] = r;
      sh_col[a] = c;
    end
  endtask

  // Offer one transaction and hold it until the block takes it. An optional
  // idle burst goes in front so gaps land on every phase of a tick.
  task automatic offer_txn(input cmd_t c, input logic [5:0] r, input logic [5:0] k,
                           input logic [2:0] a, input logic [4:0] p, input logic v,
                           input logic [3:0] m);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    cmd           <= c;
    row           <= r;
    col           <= k;
    agent_index   <= a;
    pattern_index <= p;
    cell_value    <= v;
    move_code     <= m;
    do @(posedge clk); while (!in_ready);
    txn_count++;
    case (c)
      CMD_WR_CELL: begin
        sh_grid[r*COLS + k] = v;
        sh_gset[r*COLS + k] = 1'b1;
      end
      CMD_WR_MOVE: begin
        sh_move[a*PATTERNS + p] = m;
        sh_mset[a*PATTERNS + p] = 1'b1;
      end
      CMD_PLACE: begin
        sh_row[a] = r;
        sh_col[a] = k;
      end
      CMD_TICK: begin
        tick_count++;
        shadow_tick();
      end
      default: ;
    endcase
  endtask

  // Fully random transaction; unused fields carry random bits as well.
  task automatic offer_random(input cmd_t c);
    offer_txn(c, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
              3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
              1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
  endtask

  // Row or column within four of the wrapping corner.
  function automatic logic [5:0] near_corner();
    return 6'($urandom_range(ROWS - 4, ROWS + 3));
  endfunction

  // Random transaction whose cell or position lands near the corner.
  task automatic offer_near(input cmd_t c);
    offer_txn(c, near_corner(), near_corner(), 3'($urandom_range(0, 7)),
              5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
              4'($urandom_range(0, 15)));
  endtask

  // Issue a tick, first writing any cell or table entry that the tick is
  // about to read and that the host never wrote. Agents step in order on a
  // scratch copy of the grid so later agents see earlier flips.
  task automatic send_tick();
    bit         g  [ROWS*COLS];
    bit         gs [ROWS*COLS];
    bit         ms [NAGENT*PATTERNS];
    int         cell_idx [5];
    int         a, j, r, c, idx;
    logic [4:0] code;
    logic       v;
    g  = sh_grid;
    gs = sh_gset;
    ms = sh_mset;
    for (a = 0; a < NAGENT; a++) begin
      r = sh_row[a];
      c = sh_col[a];
      cell_idx[0] = ((r == 0) ? ROWS - 1 : r - 1) * COLS + c;
      cell_idx[1] = r * COLS + ((c == COLS - 1) ? 0 : c + 1);
      cell_idx[2] = ((r == ROWS - 1) ? 0 : r + 1) * COLS + c;
      cell_idx[3] = r * COLS + ((c == 0) ? COLS - 1 : c - 1);
      cell_idx[4] = r * COLS + c;
      for (j = 0; j < 5; j++) begin
        idx = cell_idx[j];
        if (!gs[idx]) begin
          v = 1'($urandom_range(0, 1));
          offer_txn(CMD_WR_CELL, 6'(idx / COLS), 6'(idx % COLS),
                    3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)), v,
                    4'($urandom_range(0, 15)));
          g[idx]  = v;
          gs[idx] = 1'b1;
        end
        code[j] = g[idx];
      end
      if (!ms[a*PATTERNS + code]) begin
        offer_txn(CMD_WR_MOVE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                  a[2:0], code, 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
        ms[a*PATTERNS + code] = 1'b1;
      end
      g[cell_idx[4]] = ~g[cell_idx[4]];
    end
    offer_random(CMD_TICK);
  endtask

  initial begin
    int a, pick;

    // Hold reset, then release it once for the whole run.
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Place every agent near the corner before the first tick.
    for (a = 0; a < NAGENT; a++)
      offer_txn(CMD_PLACE, near_corner(), near_corner(), a[2:0],
                5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), MV_N);

    // Directed: agents on corners and edges so moves wrap both ways, cells
    // at the corners, stay codes above the last direction, extreme indexes.
    offer_txn(CMD_PLACE, 6'd0,  6'd0,  3'd0, 5'd0,  1'b0, MV_N);
    offer_txn(CMD_PLACE, 6'd63, 6'd63, 3'd1, 5'd31, 1'b1, MV_S);
    offer_txn(CMD_PLACE, 6'd0,  6'd63, 3'd2, 5'd0,  1'b0, MV_NE);
    offer_txn(CMD_PLACE, 6'd63, 6'd0,  3'd3, 5'd31, 1'b1, MV_SW);
    offer_txn(CMD_PLACE, 6'd0,  6'd32, 3'd4, 5'd0,  1'b0, MV_NW);
    offer_txn(CMD_PLACE, 6'd32, 6'd0,  3'd7, 5'd31, 1'b1, MV_W);
    offer_txn(CMD_WR_CELL, 6'd0,  6'd0,  3'd0, 5'd0,  1'b1, MV_N);
    offer_txn(CMD_WR_CELL, 6'd63, 6'd63, 3'd7, 5'd31, 1'b0, 4'd15);
    offer_txn(CMD_WR_CELL, 6'd0,  6'd63, 3'd0, 5'd0,  1'b1, MV_E);
    offer_txn(CMD_WR_CELL, 6'd63, 6'd0,  3'd7, 5'd31, 1'b1, MV_SE);
    offer_txn(CMD_WR_MOVE, 6'd0,  6'd0,  3'd0, 5'd0,  1'b0, MV_N);
    offer_txn(CMD_WR_MOVE, 6'd63, 6'd63, 3'd7, 5'd31, 1'b1, 4'd15);
    offer_txn(CMD_WR_MOVE, 6'd0,  6'd0,  3'd1, 5'd31, 1'b0, 4'd8);
    offer_txn(CMD_WR_MOVE, 6'd0,  6'd0,  3'd2, 5'd16, 1'b0, MV_NW);
    offer_txn(CMD_WR_MOVE, 6'd0,  6'd0,  3'd3, 5'd1,  1'b0, MV_SW);
    send_tick();
    send_tick();
    send_tick();

    // Random mix, ticks heaviest. One quiet stretch without idling in the
    // middle, none at all near the end, and one long receiver hold-off fed
    // by back-to-back ticks.
    while (txn_count < TOTAL_ITEMS) begin
      idle_on = !((txn_count >= 140 && txn_count < 180) ||
                  txn_count >= TOTAL_ITEMS - 50);
      if (!long_hold_req && txn_count >= 220) begin
        long_hold_req = 1'b1;
        repeat (6) send_tick();
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 40)      send_tick();
        else if (pick < 65) offer_near(CMD_WR_CELL);
        else if (pick < 85) offer_random(CMD_WR_MOVE);
        else                offer_near(CMD_PLACE);
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted step, then let any stray result show.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d transactions with %0d ticks; %0d agent steps checked,",
             txn_count, tick_count, checked);
    $display("corner wraparound, stay codes and a %0d-cycle output stall included.",
             LONG_HOLD);
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
